FILE: hw/rtl/msp_pkg.sv
// Shared types and constants for the MSP v1 frame receiver.
package msp_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_REPLY  = 8'h3E;
	localparam logic [7:0] CH_ERROR  = 8'h21;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_GOOD    = 2'd1;
	localparam logic [1:0] KIND_BAD     = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic [7:0] command_code;
		logic       error_reply;
		logic [7:0] payload_length;
	} item_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage

FILE: hw/rtl/msp_v1_frame_receiver_core.sv
// Top level of the MSP v1 reply frame receiver.
//
// Input channel rx: one received serial byte per transfer (rx_valid/rx_ready).
// Output channel res: one item per payload byte (tentative) and one frame-end
// item per checksum byte that reports good or bad (res_valid/res_ready).
// Header, direction, size and command bytes produce no output item.
//
// A byte that produces an item is written into the queue at its transfer, then
// moved from the queue head into the output register, which offers it on res.
// Throughput: one byte per cycle while res is taken each cycle; the front state
// machine advances once per byte and the queue pops once per cycle.
// When res stalls, the queue absorbs up to Depth items plus one in the output
// register; rx_ready drops only when the queue is full.
// Reset (arst_n low) returns the parser to the hunt for '$' and empties the
// queue and the output register.
module msp_v1_frame_receiver_core #(
	parameter int Depth = msp_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [1:0] item_kind,
	output logic [7:0] payload_byte,
	output logic [7:0] byte_index,
	output logic [7:0] command_code,
	output logic       error_reply,
	output logic [7:0] payload_length
);
	import msp_pkg::*;

	logic      push;
	item_t     push_item;
	item_t     head_item;
	q_status_t q_status;
	logic      pop;
	item_t     res_item;

	msp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.q_full    (q_status.full),
		.push      (push),
		.push_item (push_item)
	);

	msp_queue #(
		.Depth (Depth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.status    (q_status)
	);

	msp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_status.not_empty),
		.head_item   (head_item),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_item    (res_item)
	);

	assign item_kind      = res_item.kind;
	assign payload_byte   = res_item.payload_byte;
	assign byte_index     = res_item.byte_index;
	assign command_code   = res_item.command_code;
	assign error_reply    = res_item.error_reply;
	assign payload_length = res_item.payload_length;

`ifndef SYNTH
	a_full_means_held: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> res_valid)
		else $error("queue full while output register is empty");

	a_end_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && item_kind != KIND_PAYLOAD |-> payload_byte == 8'd0 && byte_index == 8'd0)
		else $error("frame-end item carries payload data");

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && item_kind == KIND_PAYLOAD |-> byte_index < payload_length)
		else $error("payload index beyond frame size");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> item_kind == KIND_PAYLOAD || item_kind == KIND_GOOD
			|| item_kind == KIND_BAD)
		else $error("illegal item kind");
`endif

endmodule

FILE: hw/rtl/msp_front.sv
// Front end: frame state machine that classifies each received byte.
module msp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rx_valid,
	output logic           rx_ready,
	input  logic [7:0]     rx_byte,
	input  logic           q_full,
	output logic           push,
	output msp_pkg::item_t push_item
);
	import msp_pkg::*;

	typedef enum logic [6:0] {
		PH_HUNT    = 7'b0000001,
		PH_DOLLAR  = 7'b0000010,
		PH_M       = 7'b0000100,
		PH_DIR     = 7'b0001000,
		PH_SIZE    = 7'b0010000,
		PH_PAYLOAD = 7'b0100000,
		PH_CSUM    = 7'b1000000
	} phase_t;

	phase_t     phase_q, phase_d;
	logic       err_q, err_d;
	logic [7:0] len_q, len_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] seen_q, seen_d;
	logic [7:0] xor_q, xor_d;
	logic       accept;
	logic       emit;
	item_t      item;

	assign rx_ready  = !q_full;
	assign accept    = rx_valid && !q_full;
	assign push      = accept && emit;
	assign push_item = item;

	always_comb begin
		phase_d = phase_q;
		err_d   = err_q;
		len_d   = len_q;
		cmd_d   = cmd_q;
		seen_d  = seen_q;
		xor_d   = xor_q;
		emit    = 1'b0;
		item.kind           = KIND_PAYLOAD;
		item.payload_byte   = 8'd0;
		item.byte_index     = 8'd0;
		item.command_code   = cmd_q;
		item.error_reply    = err_q;
		item.payload_length = len_q;
		case (phase_q)
			PH_DOLLAR: begin
				if (rx_byte == CH_M)
					phase_d = PH_M;
				else if (rx_byte != CH_DOLLAR)
					phase_d = PH_HUNT;
			end
			PH_M: begin
				if (rx_byte == CH_REPLY || rx_byte == CH_ERROR) begin
					err_d   = (rx_byte == CH_ERROR);
					phase_d = PH_DIR;
				end else begin
					// a '$' here may open a new header
					phase_d = (rx_byte == CH_DOLLAR) ? PH_DOLLAR : PH_HUNT;
				end
			end
			PH_DIR: begin
				len_d   = rx_byte;
				xor_d   = rx_byte;
				seen_d  = 8'd0;
				phase_d = PH_SIZE;
			end
			PH_SIZE: begin
				cmd_d   = rx_byte;
				xor_d   = xor_q ^ rx_byte;
				phase_d = (len_q == 8'd0) ? PH_CSUM : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				xor_d             = xor_q ^ rx_byte;
				emit              = 1'b1;
				item.payload_byte = rx_byte;
				item.byte_index   = seen_q;
				seen_d            = seen_q + 8'd1;
				if (seen_d >= len_q)
					phase_d = PH_CSUM;
			end
			PH_CSUM: begin
				emit      = 1'b1;
				item.kind = (xor_q == rx_byte) ? KIND_GOOD : KIND_BAD;
				phase_d   = PH_HUNT;
			end
			default: begin
				phase_d = (rx_byte == CH_DOLLAR) ? PH_DOLLAR : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			err_q   <= 1'b0;
			len_q   <= 8'd0;
			cmd_q   <= 8'd0;
			seen_q  <= 8'd0;
			xor_q   <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			err_q   <= err_d;
			len_q   <= len_d;
			cmd_q   <= cmd_d;
			seen_q  <= seen_d;
			xor_q   <= xor_d;
		end
	end

endmodule

FILE: hw/rtl/msp_queue.sv
// Small result queue between the front end and the output stage.
module msp_queue #(
	parameter int Depth = msp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  msp_pkg::item_t     push_item,
	input  logic               pop,
	output msp_pkg::item_t     head_item,
	output msp_pkg::q_status_t status
);
	import msp_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	item_t           mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign status.full      = (count_q == CntW'(Depth));
	assign status.not_empty = (count_q != '0);
	assign head_item        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			if (push && !pop)
				count_q <= count_q + CntW'(1);
			else if (pop && !push)
				count_q <= count_q - CntW'(1);
		end
	end

endmodule

FILE: hw/rtl/msp_back.sv
// Output stage: registers the queue head and hands it out on the result channel.
module msp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  msp_pkg::item_t head_item,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_ready,
	output msp_pkg::item_t res_item
);
	import msp_pkg::*;

	logic  valid_q;
	item_t item_q;
	logic  take;

	// load whenever the register is empty or its transfer completes
	assign take      = !valid_q || res_ready;
	assign pop       = q_not_empty && take;
	assign res_valid = valid_q;
	assign res_item  = item_q;

	always_ff @(posedge clk) begin
		if (pop)
			item_q <= head_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (take)
			valid_q <= q_not_empty;
	end

endmodule

FILE: sim/msp_v1_frame_receiver_core_test.sv
// Self-checking testbench for the MSP v1 reply frame receiver.
`timescale 1ns / 1ps

module msp_v1_frame_receiver_core_test;
	import msp_pkg::*;

	localparam int ITEM_TARGET = 1150;
	localparam int HOLD_CYCLES = 80;

	typedef enum logic [2:0] {
		PH_HUNT, PH_GOT_DOLLAR, PH_GOT_M, PH_GOT_DIR, PH_GOT_SIZE, PH_PAYLOAD, PH_CHECKSUM
	} parse_phase_t;

	// Frame parser model plus the queue of items it still owes.
	class frame_scoreboard;
		parse_phase_t phase;
		logic         reply_err;
		logic [7:0]   frame_len;
		logic [7:0]   frame_cmd;
		logic [7:0]   seen;
		logic [7:0]   xor_acc;
		item_t        owed_items[$];

		function new();
			phase     = PH_HUNT;
			reply_err = 1'b0;
			frame_len = '0;
			frame_cmd = '0;
			seen      = '0;
			xor_acc   = '0;
		endfunction

		function void note_byte(input logic [7:0] b);
			item_t out;
			logic  has_item;
			out      = '0;
			has_item = 1'b0;
			case (phase)
				PH_GOT_DOLLAR: begin
					if (b == CH_M)
						phase = PH_GOT_M;
					else if (b != CH_DOLLAR)
						phase = PH_HUNT;
				end
				PH_GOT_M: begin
					if (b == CH_REPLY || b == CH_ERROR) begin
						reply_err = (b == CH_ERROR);
						phase     = PH_GOT_DIR;
					end else if (b == CH_DOLLAR)
						phase = PH_GOT_DOLLAR;
					else
						phase = PH_HUNT;
				end
				PH_GOT_DIR: begin
					frame_len = b;
					xor_acc   = b;
					seen      = '0;
					phase     = PH_GOT_SIZE;
				end
				PH_GOT_SIZE: begin
					frame_cmd = b;
					xor_acc   = xor_acc ^ b;
					if (frame_len == 8'd0)
						phase = PH_CHECKSUM;
					else
						phase = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					xor_acc          = xor_acc ^ b;
					out.kind         = KIND_PAYLOAD;
					out.payload_byte = b;
					out.byte_index   = seen;
					has_item         = 1'b1;
					seen             = seen + 8'd1;
					if (seen >= frame_len)
						phase = PH_CHECKSUM;
				end
				PH_CHECKSUM: begin
					out.kind = (xor_acc == b) ? KIND_GOOD : KIND_BAD;
					has_item = 1'b1;
					phase    = PH_HUNT;
				end
				default: begin
					if (b == CH_DOLLAR)
						phase = PH_GOT_DOLLAR;
					else
						phase = PH_HUNT;
				end
			endcase
			if (has_item) begin
				out.command_code   = frame_cmd;
				out.error_reply    = reply_err;
				out.payload_length = frame_len;
				owed_items = {owed_items, out};
			end
		endfunction

		// Return an empty string on a match, else a description of the bad fields.
		function string check_item(input item_t got);
			item_t want;
			string msg;
			msg = "";
			if (owed_items.size() == 0)
				return $sformatf("item with none owed, kind %0d", got.kind);
			want = owed_items.pop_front();
			if (got.kind !== want.kind)
				msg = {msg, $sformatf(" kind %0d want %0d", got.kind, want.kind)};
			if (got.payload_byte !== want.payload_byte)
				msg = {msg, $sformatf(" byte %h want %h", got.payload_byte, want.payload_byte)};
			if (got.byte_index !== want.byte_index)
				msg = {msg, $sformatf(" index %0d want %0d", got.byte_index, want.byte_index)};
			if (got.command_code !== want.command_code)
				msg = {msg, $sformatf(" cmd %h want %h", got.command_code, want.command_code)};
			if (got.error_reply !== want.error_reply)
				msg = {msg, $sformatf(" err %b want %b", got.error_reply, want.error_reply)};
			if (got.payload_length !== want.payload_length)
				msg = {msg, $sformatf(" size %0d want %0d", got.payload_length,
					want.payload_length)};
			if (msg != "")
				msg = {"item fields:", msg};
			return msg;
		endfunction

		function int owed();
			return owed_items.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n         = 1'b0;
	logic       rx_valid       = 1'b0;
	logic       rx_ready;
	logic [7:0] rx_byte        = 8'h00;
	logic       res_valid;
	logic       res_ready      = 1'b0;
	logic [1:0] item_kind;
	logic [7:0] payload_byte;
	logic [7:0] byte_index;
	logic [7:0] command_code;
	logic       error_reply;
	logic [7:0] payload_length;

	frame_scoreboard sb = new();

	int  mismatches   = 0;
	int  bytes_sent   = 0;
	int  frame_bytes  = 0;
	int  frames_sent  = 0;
	int  items_seen   = 0;
	int  good_ends    = 0;
	int  bad_ends     = 0;
	bit  calm         = 1'b0;

	msp_v1_frame_receiver_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_ready       (rx_ready),
		.rx_byte        (rx_byte),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.item_kind      (item_kind),
		.payload_byte   (payload_byte),
		.byte_index     (byte_index),
		.command_code   (command_code),
		.error_reply    (error_reply),
		.payload_length (payload_length)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// Offer one byte and hold it until the transfer happens.
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 16) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!rx_ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// Well-formed frame with random content; the checksum is right most of the time.
	task automatic send_frame(input int size_pick);
		logic [7:0] sz;
		logic [7:0] cmd;
		logic [7:0] sum;
		logic [7:0] b;
		if (size_pick >= 0)
			sz = size_pick[7:0];
		else if ($urandom_range(0, 99) < 2)
			sz = 8'($urandom_range(0, 255));
		else
			sz = 8'($urandom_range(0, 10));
		cmd = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 20)
			send_byte(CH_DOLLAR);
		send_byte(CH_DOLLAR);
		send_byte(CH_M);
		send_byte($urandom_range(0, 1) ? CH_ERROR : CH_REPLY);
		send_byte(sz);
		send_byte(cmd);
		sum = sz ^ cmd;
		for (int i = 0; i < sz; i++) begin
			b = 8'($urandom_range(0, 255));
			sum = sum ^ b;
			send_byte(b);
		end
		if ($urandom_range(0, 99) < 85)
			send_byte(sum);
		else
			send_byte(8'($urandom_range(0, 255)));
		frame_bytes += 6 + sz;
		frames_sent++;
	endtask

	// Header cut short at a random point, optionally followed by another dollar.
	task automatic send_broken_header();
		int cut;
		cut = $urandom_range(1, 3);
		send_byte(CH_DOLLAR);
		if (cut >= 2)
			send_byte(CH_M);
		if (cut >= 3)
			send_byte($urandom_range(0, 99) < 30 ? CH_DOLLAR : 8'($urandom_range(0, 255)));
		else
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		rx_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.owed() != 0);
	endtask

	// Sender
	initial begin
		logic [7:0] directed[$];
		int         pick;
		int         guard;
		bit         paused;
		paused = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// repeated dollar, error direction, empty payload, good checksum
		directed = {CH_DOLLAR, CH_DOLLAR, CH_M, CH_ERROR, 8'h00, 8'hFF, 8'hFF};
		// bad direction that is a dollar, then a reply frame with a bad checksum
		directed = {directed, CH_DOLLAR, CH_M, CH_DOLLAR, CH_M, CH_REPLY, 8'h02, 8'h00,
			8'hFF, 8'h80, 8'h00};
		// bad direction of another kind, lone M, dollar then junk
		directed = {directed, CH_DOLLAR, CH_M, 8'h51, CH_M, CH_DOLLAR, 8'h00};
		foreach (directed[i])
			send_byte(directed[i]);
		wait_drained();

		send_frame(255);
		while (bytes_sent < ITEM_TARGET) begin
			calm = (frame_bytes >= 450 && frame_bytes < 650);
			if (!paused && frame_bytes >= 800) begin
				paused = 1'b1;
				wait_drained();
			end
			pick = $urandom_range(0, 99);
			if (pick < 80)
				send_frame(-1);
			else if (pick < 90)
				send_broken_header();
			else
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom_range(0, 255)));
		end
		calm = 1'b0;
		rx_valid <= 1'b0;

		guard = 0;
		while (sb.owed() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (sb.owed() != 0)
			report_mismatch($sformatf("%0d items never came out", sb.owed()));

		$display("sent %0d bytes in %0d random frames plus directed and noise bytes",
			bytes_sent, frames_sent);
		$display("checked %0d items: %0d good frame ends, %0d bad frame ends",
			items_seen, good_ends, bad_ends);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Receiver: check each transfer, idle at random, and stall once for a long stretch.
	initial begin
		item_t got;
		string msg;
		int    hold_left;
		bit    hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) begin
				got.kind           = item_kind;
				got.payload_byte   = payload_byte;
				got.byte_index     = byte_index;
				got.command_code   = command_code;
				got.error_reply    = error_reply;
				got.payload_length = payload_length;
				msg = sb.check_item(got);
				if (msg != "")
					report_mismatch(msg);
				items_seen++;
				if (item_kind == KIND_GOOD)
					good_ends++;
				else if (item_kind == KIND_BAD)
					bad_ends++;
			end
			if (!hold_done && items_seen >= 150) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 16)
				res_ready <= 1'b0;
			else
				res_ready <= 1'b1;
		end
	end

endmodule

FILE: filelist.f
hw/rtl/msp_pkg.sv
hw/rtl/msp_front.sv
hw/rtl/msp_queue.sv
hw/rtl/msp_back.sv
hw/rtl/msp_v1_frame_receiver_core.sv
sim/msp_v1_frame_receiver_core_test.sv
